@@ hw/rtl/pfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package pfd_pkg;

	localparam int DATA_W   = 32;
	localparam int DT_W     = 31;
	localparam int COEF_W   = 17;
	localparam int BOUND_W  = 31;
	localparam int DRIVE_W  = 31;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_STEPS = 48;
	localparam int DIV_CNT_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOUND    = 3'd5;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic signed [63:0] ERR_WINDOW = 64'sd6553600;
	localparam logic signed [63:0] OUT_LIMIT  = 64'sd655360000;

	typedef struct packed {
		logic load;       // capture input, compute err
		logic div_start;  // begin raw derivative divide
		logic div_step;   // one restoring divide step
		logic filt;       // compute raw and filter products
		logic filt_fin;   // finalize filtered derivative, P and D products
		logic pd;         // sum P and D terms, err*dt product
		logic integ;      // integral candidate and update, I product
		logic iprod;      // final sum and saturation into drive
		logic clear;      // clear request
	} pfd_cmd_t;

	typedef struct packed {
		logic div_done;
		logic is_clear;
	} pfd_sts_t;

endpackage

@@ hw/rtl/pfd_datapath.sv @@
// ----------------------------------------------------------------------------
// pfd_datapath
// Error, serial divide, filter, PID products and saturation.
// ----------------------------------------------------------------------------
module pfd_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pfd_pkg::pfd_cmd_t                    cmd,
	output pfd_pkg::pfd_sts_t                    sts,
	input  logic                                 cfg_we,
	input  logic [pfd_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [pfd_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                 func,
	input  logic signed [pfd_pkg::DATA_W-1:0]    measurement,
	input  logic [pfd_pkg::DT_W-1:0]             time_step,
	output logic signed [pfd_pkg::DRIVE_W-1:0]   drive_q
);

	logic signed [31:0] setpoint_q, gain_p_q, gain_i_q, gain_d_q;
	logic [16:0] coef_q;
	logic [30:0] bound_q;
	logic signed [31:0] prev_err_q, filt_q, integ_q;

	logic func_q;
	logic [30:0] dt_q;
	logic signed [31:0] err_q;
	logic neg_q;
	logic [47:0] quo_q;
	logic [47:0] num_q;
	logic [31:0] rem_q;
	logic [pfd_pkg::DIV_CNT_W-1:0] cnt_q;
	logic signed [63:0] pa_q, pb_q;
	logic signed [63:0] tot_q;

	logic signed [32:0] err_full;
	logic signed [31:0] err_sat;
	logic signed [32:0] diff;
	logic [32:0] diff_mag;
	logic [32:0] rem_sh;
	logic [48:0] q_signed;
	logic signed [63:0] raw_w;
	logic signed [31:0] raw_sat;
	logic [16:0] c_eff;
	logic signed [63:0] fsum;
	logic signed [63:0] fsh;
	logic signed [31:0] deriv_sat;
	logic signed [63:0] cand;
	logic signed [63:0] bnd;
	logic signed [31:0] integ_new;
	logic signed [63:0] total;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) sat32 = 32'sh7fffffff;
		else if (x < -64'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = x[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			coef_q <= pfd_pkg::ONE_Q16;
			bound_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				pfd_pkg::REG_SETPOINT: setpoint_q <= cfg_data;
				pfd_pkg::REG_GAIN_P:   gain_p_q <= cfg_data;
				pfd_pkg::REG_GAIN_I:   gain_i_q <= cfg_data;
				pfd_pkg::REG_GAIN_D:   gain_d_q <= cfg_data;
				pfd_pkg::REG_COEF:     coef_q <= cfg_data[16:0];
				pfd_pkg::REG_BOUND:    bound_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		err_full = 33'(setpoint_q) - 33'(measurement);
		if (err_full > 33'sd2147483647) err_sat = 32'sh7fffffff;
		else if (err_full < -33'sd2147483648) err_sat = 32'sh80000000;
		else err_sat = err_full[31:0];
		diff = 33'(err_q) - 33'(prev_err_q);
		diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
		rem_sh = {rem_q, num_q[47]};
		q_signed = neg_q ? 49'(-{1'b0, quo_q}) : {1'b0, quo_q};
		raw_w = (dt_q == '0) ? 64'sd0 : 64'(signed'(q_signed));
		raw_sat = sat32(raw_w);
		c_eff = (coef_q > pfd_pkg::ONE_Q16) ? pfd_pkg::ONE_Q16 : coef_q;
		fsum = pa_q + pb_q;
		fsh = fsum >>> 16;
		deriv_sat = sat32(fsh);
		if (64'(err_q) < pfd_pkg::ERR_WINDOW && 64'(err_q) > -pfd_pkg::ERR_WINDOW)
			cand = 64'(integ_q) + (pa_q >>> 16);
		else
			cand = '0;
		bnd = 64'(signed'({1'b0, bound_q}));
		if (cand > bnd) cand = bnd;
		if (cand < -bnd) cand = -bnd;
		if (cand < pfd_pkg::OUT_LIMIT && cand > -pfd_pkg::OUT_LIMIT)
			integ_new = cand[31:0];
		else
			integ_new = integ_q;
		total = tot_q + (pa_q >>> 16);
		if (total > pfd_pkg::OUT_LIMIT) total = pfd_pkg::OUT_LIMIT;
		if (total < -pfd_pkg::OUT_LIMIT) total = -pfd_pkg::OUT_LIMIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			filt_q <= '0;
			integ_q <= '0;
		end else begin
			if (cmd.clear) integ_q <= '0;
			if (cmd.div_start) prev_err_q <= err_q;
			if (cmd.filt_fin) filt_q <= deriv_sat;
			if (cmd.integ) integ_q <= integ_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			dt_q <= time_step;
			err_q <= err_sat;
		end
		if (cmd.div_start) begin
			// magnitude of diff << 16, sign applied after the divide
			neg_q <= diff[32];
			num_q <= {diff_mag[31:0], 16'd0};
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_sh >= {2'b0, dt_q}) begin
				rem_q <= 32'(rem_sh - {2'b0, dt_q});
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= rem_sh[31:0];
				quo_q <= {quo_q[46:0], 1'b0};
			end
			num_q <= {num_q[46:0], 1'b0};
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.filt) begin
			pa_q <= 64'(raw_sat) * 64'(signed'({1'b0, c_eff}));
			pb_q <= 64'(filt_q) * 64'(signed'({1'b0, 17'(pfd_pkg::ONE_Q16 - c_eff)}));
		end
		if (cmd.filt_fin) begin
			pa_q <= 64'(err_q) * 64'(gain_p_q);
			pb_q <= 64'(deriv_sat) * 64'(gain_d_q);
		end
		if (cmd.pd) begin
			tot_q <= (pa_q >>> 16) + (pb_q >>> 16);
			pa_q <= 64'(err_q) * 64'(signed'({1'b0, dt_q}));
		end
		if (cmd.integ) begin
			pa_q <= 64'(integ_new) * 64'(gain_i_q);
		end
		if (cmd.iprod) drive_q <= total[30:0];
		if (cmd.clear) drive_q <= '0;
	end

	assign sts.div_done = (cnt_q == 6'(pfd_pkg::DIV_STEPS - 1));
	assign sts.is_clear = func_q;

endmodule

@@ hw/rtl/pfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfd_ctrl
// Sequencer for one control step and the output handshake.
// ----------------------------------------------------------------------------
module pfd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  pfd_pkg::pfd_sts_t  sts,
	output pfd_pkg::pfd_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_FILT = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_PD   = 3'd5;
	localparam logic [2:0] S_INT  = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0] state_q;
	logic out_valid_q;
	logic accept;
	logic out_busy;
	logic done;

	// a waiting result holds the next transaction only in its last phase
	assign out_busy = out_valid_q && out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign done = ((state_q == S_OUT) || (state_q == S_DEC && sts.is_clear)) && !out_busy;

	always_comb begin
		cmd = '0;
		cmd.load = accept;
		unique case (state_q)
			S_IDLE: ;
			S_DEC: begin
				cmd.clear = sts.is_clear && !out_busy;
				cmd.div_start = !sts.is_clear;
			end
			S_DIV:  cmd.div_step = 1'b1;
			S_FILT: cmd.filt = 1'b1;
			S_FIN:  cmd.filt_fin = 1'b1;
			S_PD:   cmd.pd = 1'b1;
			S_INT:  cmd.integ = 1'b1;
			S_OUT:  cmd.iprod = !out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (done) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_DEC;
				S_DEC: begin
					if (sts.is_clear) begin
						if (!out_busy) state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV:  if (sts.div_done) state_q <= S_FILT;
				S_FILT: state_q <= S_FIN;
				S_FIN:  state_q <= S_PD;
				S_PD:   state_q <= S_INT;
				S_INT:  state_q <= S_OUT;
				S_OUT:  if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ hw/rtl/pid_filtered_derivative_step.sv @@
// ----------------------------------------------------------------------------
// pid_filtered_derivative_step
// Positional PID step with filtered derivative, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// One transaction at a time, taken only while idle. A control step passes
// through the decode state, the bit-serial restoring divide of the raw
// derivative, and the filter, finalize, P/D, integral and output states for
// the shared multiply pairs and the final sum; the next transaction is taken
// once the block is back in idle. A clear request finishes in the decode state.
// The output register holds a result until taken while the next transaction
// enters; a step that finishes while the previous result still waits holds in
// its last phase. Write configuration only while no transaction is in flight.
module pid_filtered_derivative_step (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pfd_pkg::CFG_IDX_W-1:0]        cfg_idx,
	input  logic [pfd_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 func,
	input  logic signed [pfd_pkg::DATA_W-1:0]    measurement,
	input  logic [pfd_pkg::DT_W-1:0]             time_step,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pfd_pkg::DRIVE_W-1:0]   drive
);

	pfd_pkg::pfd_cmd_t cmd;
	pfd_pkg::pfd_sts_t sts;

	pfd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.sts(sts), .cmd(cmd)
	);

	pfd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.func(func), .measurement(measurement), .time_step(time_step),
		.drive_q(drive)
	);

endmodule

@@ tb/pfd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfd_checker
// Watches the config port and both channels of the PID step, predicts each
// drive value from its own copy of the registers and state, and compares.
// ----------------------------------------------------------------------------
module pfd_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pfd_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [pfd_pkg::DATA_W-1:0]         cfg_data,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               func,
	input  logic signed [pfd_pkg::DATA_W-1:0]  measurement,
	input  logic [pfd_pkg::DT_W-1:0]           time_step,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic signed [pfd_pkg::DRIVE_W-1:0] drive,
	output int                                 failures,
	output int                                 pending
);

	localparam longint Q_ONE    = 65536;
	localparam longint WINDOW   = 100 * 65536;
	localparam longint DRV_MAX  = 10000 * 65536;

	longint sp, kp, ki, kd, coef, bound;
	longint err_q, fderiv_q, integ_q;
	logic [pfd_pkg::DRIVE_W-1:0] drive_q[$];

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic logic [pfd_pkg::DRIVE_W-1:0] next_drive(logic f, longint meas,
		longint dt);
		longint err, raw, c, deriv, total, cand;
		if (f) begin
			integ_q = 0;
			return '0;
		end
		err = sat32(sp - meas);
		raw = (dt != 0) ? sat32(((err - err_q) * Q_ONE) / dt) : 0;
		err_q = err;
		c = (coef > Q_ONE) ? Q_ONE : coef;
		deriv = sat32((c * raw + (Q_ONE - c) * fderiv_q) >>> 16);
		fderiv_q = deriv;
		total = ((err * kp) >>> 16) + ((deriv * kd) >>> 16);
		// integrate only inside the error window
		cand = (err < WINDOW && err > -WINDOW) ? integ_q + ((err * dt) >>> 16) : 0;
		if (cand > bound)
			cand = bound;
		if (cand < -bound)
			cand = -bound;
		if (cand < DRV_MAX && cand > -DRV_MAX)
			integ_q = cand;
		total += (integ_q * ki) >>> 16;
		if (total > DRV_MAX)
			total = DRV_MAX;
		if (total < -DRV_MAX)
			total = -DRV_MAX;
		return total[pfd_pkg::DRIVE_W-1:0];
	endfunction

	assign pending = drive_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp = 0; kp = 0; ki = 0; kd = 0; coef = Q_ONE; bound = 0;
			err_q = 0; fderiv_q = 0; integ_q = 0;
			drive_q.delete();
			failures = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					pfd_pkg::REG_SETPOINT: sp = longint'($signed(cfg_data));
					pfd_pkg::REG_GAIN_P:   kp = longint'($signed(cfg_data));
					pfd_pkg::REG_GAIN_I:   ki = longint'($signed(cfg_data));
					pfd_pkg::REG_GAIN_D:   kd = longint'($signed(cfg_data));
					pfd_pkg::REG_COEF:     coef = longint'(cfg_data[pfd_pkg::COEF_W-1:0]);
					pfd_pkg::REG_BOUND:    bound = longint'(cfg_data[pfd_pkg::BOUND_W-1:0]);
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (drive_q.size() == 0) begin
					$display("%0t: unexpected drive transaction: expected none, actual %0d",
						$time, drive);
					failures++;
				end else begin
					logic [pfd_pkg::DRIVE_W-1:0] want;
					want = drive_q.pop_front();
					if (want !== drive) begin
						$display("%0t: drive mismatch: expected %0d, actual %0d",
							$time, $signed(want), drive);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall)
				drive_q.push_back(next_drive(func, longint'(measurement),
					longint'(time_step)));
		end
	end
endmodule

@@ tb/tb_pid_filtered_derivative_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pid_filtered_derivative_step
// Drives directed and random control steps and clear requests through the
// PID step over several register settings; the checker gives the count.
// ----------------------------------------------------------------------------
module tb_pid_filtered_derivative_step;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [pfd_pkg::CFG_IDX_W-1:0] cfg_idx = pfd_pkg::REG_SETPOINT;
	logic [pfd_pkg::DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic func = 0;
	logic signed [pfd_pkg::DATA_W-1:0] measurement = '0;
	logic [pfd_pkg::DT_W-1:0] time_step = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [pfd_pkg::DRIVE_W-1:0] drive;
	int failures, pending;
	bit quiet = 0;
	longint sp_cur = 0;

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	pid_filtered_derivative_step dut (.*);
	pfd_checker chk (.*);

	always @(negedge clk)
		out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 9);

	task automatic write_reg(logic [pfd_pkg::CFG_IDX_W-1:0] idx,
		logic [pfd_pkg::DATA_W-1:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx == pfd_pkg::REG_SETPOINT)
			sp_cur = longint'($signed(val));
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic send_step(logic f, logic [pfd_pkg::DATA_W-1:0] m,
		logic [pfd_pkg::DT_W-1:0] dt);
		in_valid <= 1;
		func <= f;
		measurement <= m;
		time_step <= dt;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		@(negedge clk);
		if (!quiet && $urandom_range(0, 99) < 9) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 70)) @(negedge clk);
		end
	endtask

	task automatic set_all(int mode);
		logic [pfd_pkg::DATA_W-1:0] g;
		case (mode)
			0: begin
				write_reg(pfd_pkg::REG_SETPOINT,
					$urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000);
				for (int i = 1; i <= 3; i++) begin
					g = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
					write_reg(i[pfd_pkg::CFG_IDX_W-1:0], g);
				end
				write_reg(pfd_pkg::REG_COEF, $urandom_range(0, 65536));
				write_reg(pfd_pkg::REG_BOUND, $urandom_range(0, 32'h0200_0000));
			end
			1: begin
				write_reg(pfd_pkg::REG_SETPOINT, $urandom());
				write_reg(pfd_pkg::REG_GAIN_P, $urandom());
				write_reg(pfd_pkg::REG_GAIN_I, $urandom());
				write_reg(pfd_pkg::REG_GAIN_D, $urandom());
				write_reg(pfd_pkg::REG_COEF, $urandom());
				write_reg(pfd_pkg::REG_BOUND, $urandom());
			end
			2: begin
				write_reg(pfd_pkg::REG_SETPOINT, 32'h8000_0000);
				write_reg(pfd_pkg::REG_GAIN_P, 32'h7fff_ffff);
				write_reg(pfd_pkg::REG_GAIN_I, 32'h8000_0000);
				write_reg(pfd_pkg::REG_GAIN_D, 32'h7fff_ffff);
				write_reg(pfd_pkg::REG_COEF, 32'h0001_ffff);
				write_reg(pfd_pkg::REG_BOUND, 32'h7fff_ffff);
			end
			default: begin
				write_reg(pfd_pkg::REG_SETPOINT, 32'h7fff_ffff);
				write_reg(pfd_pkg::REG_GAIN_P, 32'h8000_0000);
				write_reg(pfd_pkg::REG_GAIN_I, 32'h7fff_ffff);
				write_reg(pfd_pkg::REG_GAIN_D, 32'h8000_0000);
				write_reg(pfd_pkg::REG_COEF, 32'h0000_0000);
				write_reg(pfd_pkg::REG_BOUND, 32'h0000_0000);
			end
		endcase
	endtask

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		longint m;
		logic [pfd_pkg::DT_W-1:0] dt;
		repeat (8) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: modest gains, filter weight above one
		write_reg(pfd_pkg::REG_SETPOINT, 32'h0001_0000);
		write_reg(pfd_pkg::REG_GAIN_P, 32'h0002_0000);
		write_reg(pfd_pkg::REG_GAIN_I, 32'h0000_8000);
		write_reg(pfd_pkg::REG_GAIN_D, 32'hffff_0000);
		write_reg(pfd_pkg::REG_COEF, 32'h0001_ffff);
		write_reg(pfd_pkg::REG_BOUND, 32'h0010_0000);
		send_step(0, 32'h0000_0000, 31'd0);
		send_step(0, 32'h0000_8000, 31'h0001_0000);
		send_step(0, 32'h7fff_ffff, 31'd1);
		send_step(0, 32'h8000_0000, 31'd1);
		send_step(0, 32'h8000_0000, 31'h7fff_ffff);
		send_step(0, 32'h0000_0000, 31'h7fff_ffff);
		send_step(1, 32'hffff_ffff, 31'h7fff_ffff);
		send_step(0, 32'h0064_0000, 31'h0001_0000);
		send_step(0, 32'hff9c_0000, 31'h0001_0000);
		drain();
		set_all(2);
		send_step(0, 32'h7fff_ffff, 31'd1);
		send_step(0, 32'h0000_0000, 31'd2);
		send_step(0, 32'h8000_0000, 31'h0000_0001);
		send_step(1, 32'h0000_0000, 31'd0);
		drain();
		set_all(3);
		send_step(0, 32'h8000_0000, 31'd1);
		send_step(0, 32'h7fff_ffff, 31'h7fff_ffff);
		send_step(0, 32'h7fff_0000, 31'd0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			set_all((ph == 3 || ph == 6) ? 1 : (ph == 7 ? 2 : 0));
			quiet = (ph == 4);
			for (int n = 0; n < 125; n++) begin
				if ($urandom_range(0, 9) == 0)
					m = longint'($signed($urandom()));
				else
					m = sp_cur + longint'($urandom_range(0, 32'h00d0_0000)) - 64'sd6815744;
				if (m > 64'sd2147483647)
					m = 64'sd2147483647;
				if (m < -64'sd2147483648)
					m = -64'sd2147483648;
				case ($urandom_range(0, 9))
					0: dt = '0;
					1: dt = $urandom();
					default: dt = $urandom_range(1, 32'h0002_0000);
				endcase
				send_step($urandom_range(0, 24) == 0, m[pfd_pkg::DATA_W-1:0], dt);
			end
			in_valid <= 0;
			quiet = 0;
			drain();
		end

		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
